// ===== hw/rtl/rau_pkg.sv =====
// rau_pkg: shared widths, opcode and status codes, sequencer state types and
// the divider request/response structs for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  // Datapath word: holds cross products, sums and all gcd intermediates.
  localparam int DW = 34;
  // Multiplier operand: a reduced 16-bit input can reach +32768.
  localparam int MW = 17;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_IN  = 2'd1;
  localparam logic [1:0] STAT_ZERO_RES = 2'd2;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [MW-1:0] opnd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_CHK,
    S_RED_MOD,
    S_RED_DIVN,
    S_RED_WN,
    S_RED_DIVD,
    S_RED_WD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_EVAL
  } state_t;

  // Which fraction the reduction sequence is working on.
  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } phase_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rau_mul.sv =====
// rau_mul: shared signed multiplier with a registered product.
// Depends on rau_pkg.
module rau_mul (
  input  logic          clk,
  input  rau_pkg::opnd_t a,
  input  rau_pkg::opnd_t b,
  output rau_pkg::word_t p
);

  rau_pkg::word_t p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/rau_div.sv =====
// rau_div: bit-serial signed divider, truncated quotient, remainder takes the
// dividend's sign. One quotient bit per cycle. Depends on rau_pkg.
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);

  localparam int DW = rau_pkg::DW;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          q_neg_r, q_neg_nxt;
  logic          r_neg_r, r_neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic [DW-1:0] dnd_u, dvs_u;
  logic [DW:0]   shifted, diff;

  assign dnd_u   = req.dividend;
  assign dvs_u   = req.divisor;
  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    q_neg_nxt = q_neg_r;
    r_neg_nxt = r_neg_r;
    cnt_nxt   = cnt_r;
    if (req.start) begin
      rem_nxt   = '0;
      quo_nxt   = dnd_u[DW-1] ? (~dnd_u + 1'b1) : dnd_u;
      dvs_nxt   = dvs_u[DW-1] ? (~dvs_u + 1'b1) : dvs_u;
      q_neg_nxt = dnd_u[DW-1] ^ dvs_u[DW-1];
      r_neg_nxt = dnd_u[DW-1];
      cnt_nxt   = CW'(DW);
    end else if (cnt_r != '0) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
    done_nxt = !req.start && (cnt_r == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    q_neg_r <= q_neg_nxt;
    r_neg_r <= r_neg_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = q_neg_r ? rau_pkg::word_t'(~quo_r + 1'b1) : rau_pkg::word_t'(quo_r);
  assign rsp.rem  = r_neg_r ? rau_pkg::word_t'(~rem_r + 1'b1) : rau_pkg::word_t'(rem_r);

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (cnt_r == CW'(DW)))
    else $error("divider start did not load the step counter");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0))
    else $error("divider done while steps remain");

endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// rational_arith_unit: top level. Sequencer for fraction reduction, cross
// products and compare. Depends on rau_pkg, rau_mul and rau_div.

// An operation is taken when start is high and busy is low; the result word
// appears for one cycle with out_valid and cannot be held off, so capture it
// then. A zero input denominator or an unused opcode answers in the cycle
// after start. Otherwise each input fraction and then the result are reduced
// by Euclid's algorithm on a bit-serial divider: the remainder steps find the
// gcd, then numerator and denominator are each divided by it. The three
// products are formed on the shared multiplier between the input and result
// reductions. Compare and a zero result denominator skip the third
// reduction.
module rational_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic signed [15:0] in_a_num,
  input  logic signed [15:0] in_a_den,
  input  logic signed [15:0] in_b_num,
  input  logic signed [15:0] in_b_den,
  output logic               out_valid,
  output logic signed [32:0] out_res_num,
  output logic signed [31:0] out_res_den,
  output logic [1:0]         out_status,
  output logic               out_is_equal,
  output logic               out_is_less,
  output logic               out_is_greater
);

  rau_pkg::state_t state_r, state_nxt;
  rau_pkg::phase_t phase_r, phase_nxt;

  logic [2:0]     op_r;
  rau_pkg::opnd_t an_r, ad_r, bn_r, bd_r;
  rau_pkg::word_t wn_r, wd_r, wx_r, wy_r;
  rau_pkg::word_t p_r, q_r, rd_r;
  rau_pkg::word_t rn;

  rau_pkg::div_req_t div_req;
  rau_pkg::div_rsp_t div_rsp;
  rau_pkg::opnd_t    mul_a, mul_b;
  rau_pkg::word_t    mul_p;

  logic               out_valid_r;
  logic signed [32:0] res_num_r, res_num_nxt;
  logic signed [31:0] res_den_r, res_den_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               eq_r, eq_nxt, lt_r, lt_nxt, gt_r, gt_nxt;
  logic               out_load;

  logic accept, den_zero, op_unused;

  assign accept    = start && (state_r == rau_pkg::S_IDLE);
  assign den_zero  = (in_a_den == '0) || (in_b_den == '0);
  assign op_unused = (in_opcode > rau_pkg::OP_CMP);

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    unique case (op_r)
      rau_pkg::OP_ADD: rn = p_r + q_r;
      rau_pkg::OP_SUB: rn = p_r - q_r;
      default:         rn = p_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (start) begin
          phase_nxt = rau_pkg::PH_A;
          if (!den_zero && !op_unused) state_nxt = rau_pkg::S_RED_CHK;
        end
      end
      rau_pkg::S_RED_CHK:
        state_nxt = (wy_r == '0) ? rau_pkg::S_RED_DIVN : rau_pkg::S_RED_MOD;
      rau_pkg::S_RED_MOD:
        if (div_rsp.done) state_nxt = rau_pkg::S_RED_CHK;
      rau_pkg::S_RED_DIVN: state_nxt = rau_pkg::S_RED_WN;
      rau_pkg::S_RED_WN:
        if (div_rsp.done) state_nxt = rau_pkg::S_RED_DIVD;
      rau_pkg::S_RED_DIVD: state_nxt = rau_pkg::S_RED_WD;
      rau_pkg::S_RED_WD: begin
        if (div_rsp.done) begin
          unique case (phase_r)
            rau_pkg::PH_A: begin
              state_nxt = rau_pkg::S_RED_CHK;
              phase_nxt = rau_pkg::PH_B;
            end
            rau_pkg::PH_B: state_nxt = rau_pkg::S_MUL0;
            default:       state_nxt = rau_pkg::S_IDLE;
          endcase
        end
      end
      rau_pkg::S_MUL0: state_nxt = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3: state_nxt = rau_pkg::S_EVAL;
      rau_pkg::S_EVAL: begin
        if (op_r == rau_pkg::OP_CMP || rd_r == '0) begin
          state_nxt = rau_pkg::S_IDLE;
        end else begin
          state_nxt = rau_pkg::S_RED_CHK;
          phase_nxt = rau_pkg::PH_R;
        end
      end
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: divider request, multiplier operands, result word
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = wx_r;
    div_req.divisor  = wy_r;
    mul_a            = an_r;
    mul_b            = bd_r;
    out_load         = 1'b0;
    res_num_nxt      = '0;
    res_den_nxt      = '0;
    status_nxt       = rau_pkg::STAT_OK;
    eq_nxt           = 1'b0;
    lt_nxt           = 1'b0;
    gt_nxt           = 1'b0;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (start && (den_zero || op_unused)) begin
          out_load = 1'b1;
          if (den_zero) status_nxt = rau_pkg::STAT_ZERO_IN;
        end
      end
      rau_pkg::S_RED_CHK: div_req.start = (wy_r != '0);
      rau_pkg::S_RED_DIVN: begin
        div_req.start    = 1'b1;
        div_req.dividend = wn_r;
        div_req.divisor  = wx_r;
      end
      rau_pkg::S_RED_DIVD: begin
        div_req.start    = 1'b1;
        div_req.dividend = wd_r;
        div_req.divisor  = wx_r;
      end
      rau_pkg::S_RED_WD: begin
        if (div_rsp.done && phase_r == rau_pkg::PH_R) begin
          out_load    = 1'b1;
          res_num_nxt = wn_r[32:0];
          res_den_nxt = div_rsp.quot[31:0];
        end
      end
      rau_pkg::S_MUL0: begin
        mul_a = an_r;
        mul_b = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
      end
      rau_pkg::S_MUL1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      rau_pkg::S_MUL2: begin
        mul_a = ad_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
      end
      rau_pkg::S_EVAL: begin
        if (op_r == rau_pkg::OP_CMP) begin
          out_load = 1'b1;
          eq_nxt   = (p_r == q_r);
          lt_nxt   = (p_r < q_r);
          gt_nxt   = (q_r < p_r);
        end else if (rd_r == '0) begin
          out_load   = 1'b1;
          status_nxt = rau_pkg::STAT_ZERO_RES;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      phase_r     <= rau_pkg::PH_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_load;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        if (start) begin
          op_r <= in_opcode;
          wn_r <= rau_pkg::word_t'(in_a_num);
          wd_r <= rau_pkg::word_t'(in_a_den);
          wx_r <= rau_pkg::word_t'(in_a_num);
          wy_r <= rau_pkg::word_t'(in_a_den);
          bn_r <= rau_pkg::opnd_t'(in_b_num);
          bd_r <= rau_pkg::opnd_t'(in_b_den);
        end
      end
      rau_pkg::S_RED_MOD: begin
        if (div_rsp.done) begin
          wx_r <= wy_r;
          wy_r <= div_rsp.rem;
        end
      end
      rau_pkg::S_RED_WN: begin
        if (div_rsp.done) wn_r <= div_rsp.quot;
      end
      rau_pkg::S_RED_WD: begin
        if (div_rsp.done) begin
          unique case (phase_r)
            rau_pkg::PH_A: begin
              an_r <= rau_pkg::opnd_t'(wn_r);
              ad_r <= rau_pkg::opnd_t'(div_rsp.quot);
              wn_r <= rau_pkg::word_t'(bn_r);
              wd_r <= rau_pkg::word_t'(bd_r);
              wx_r <= rau_pkg::word_t'(bn_r);
              wy_r <= rau_pkg::word_t'(bd_r);
            end
            rau_pkg::PH_B: begin
              bn_r <= rau_pkg::opnd_t'(wn_r);
              bd_r <= rau_pkg::opnd_t'(div_rsp.quot);
            end
            default: ;
          endcase
        end
      end
      rau_pkg::S_MUL1: p_r  <= mul_p;
      rau_pkg::S_MUL2: q_r  <= mul_p;
      rau_pkg::S_MUL3: rd_r <= mul_p;
      rau_pkg::S_EVAL: begin
        wn_r <= rn;
        wd_r <= rd_r;
        wx_r <= rn;
        wy_r <= rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_num_r <= res_num_nxt;
      res_den_r <= res_den_nxt;
      status_r  <= status_nxt;
      eq_r      <= eq_nxt;
      lt_r      <= lt_nxt;
      gt_r      <= gt_nxt;
    end
  end

  assign busy           = (state_r != rau_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_res_num    = res_num_r;
  assign out_res_den    = res_den_r;
  assign out_status     = status_r;
  assign out_is_equal   = eq_r;
  assign out_is_less    = lt_r;
  assign out_is_greater = gt_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while sequencer still busy");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && den_zero) |=> (out_valid && out_status == rau_pkg::STAT_ZERO_IN))
    else $error("zero input denominator not answered next cycle");

  a_zero_res_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rau_pkg::STAT_ZERO_RES) |-> (op_r == rau_pkg::OP_DIV))
    else $error("zero result denominator on a non-divide word");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == rau_pkg::OP_CMP && out_status == rau_pkg::STAT_OK)
      |-> $onehot({out_is_equal, out_is_less, out_is_greater}))
    else $error("compare flags not one-hot");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

// ===== tb/sv/tb_rational_arith_unit.sv =====
// tb_rational_arith_unit: self-checking testbench for the rational arithmetic unit.
// Drives directed and random fraction words through start/busy and checks every
// out_valid word against a built-in predictor or a word typed into its directed row. Depends on rau_pkg and the RTL.
module tb_rational_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1825;
  localparam int DRAIN_EVERY  = 400;
  localparam int CYCLE_LIMIT  = 40_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic signed [32:0] num;
    logic signed [31:0] den;
    logic [1:0]         status;
    logic               is_equal;
    logic               is_less;
    logic               is_greater;
  } frac_result_t;

  localparam frac_result_t ZERO_IN_WORD  =
    '{33'sd0, 32'sd0, rau_pkg::STAT_ZERO_IN, 1'b0, 1'b0, 1'b0};
  localparam frac_result_t ZERO_RES_WORD =
    '{33'sd0, 32'sd0, rau_pkg::STAT_ZERO_RES, 1'b0, 1'b0, 1'b0};
  localparam frac_result_t BLANK_WORD    =
    '{33'sd0, 32'sd0, rau_pkg::STAT_OK, 1'b0, 1'b0, 1'b0};

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] an;
    logic signed [15:0] ad;
    logic signed [15:0] bn;
    logic signed [15:0] bd;
    bit                 typed;
    frac_result_t       want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_opcode = '0;
  logic signed [15:0] in_a_num = '0;
  logic signed [15:0] in_a_den = '0;
  logic signed [15:0] in_b_num = '0;
  logic signed [15:0] in_b_den = '0;
  logic               out_valid;
  logic signed [32:0] out_res_num;
  logic signed [31:0] out_res_den;
  logic [1:0]         out_status;
  logic               out_is_equal;
  logic               out_is_less;
  logic               out_is_greater;

  frac_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  frac_result_t got_word;
  frac_result_t want_word;
  int           mismatches = 0;
  int           results_seen = 0;
  int           zero_in_seen = 0;
  int           zero_res_seen = 0;
  int           words_sent = 0;
  int           op_count[8];

  rational_arith_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Euclid with truncated remainder: each remainder takes the sign of its dividend.
  function automatic longint gcd_trunc(longint x, longint y);
    longint r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic void cancel_common(inout longint n, inout longint d);
    longint g;
    g = gcd_trunc(n, d);
    if (g != 0) begin
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic frac_result_t rational_result(logic [2:0] op,
                                                   logic signed [15:0] an_i,
                                                   logic signed [15:0] ad_i,
                                                   logic signed [15:0] bn_i,
                                                   logic signed [15:0] bd_i);
    longint an, ad, bn, bd, rn, rd, p, q;
    frac_result_t r;
    r  = BLANK_WORD;
    an = an_i;
    ad = ad_i;
    bn = bn_i;
    bd = bd_i;
    rn = 0;
    rd = 0;
    if (ad == 0 || bd == 0) begin
      r.status = rau_pkg::STAT_ZERO_IN;
    end else begin
      cancel_common(an, ad);
      cancel_common(bn, bd);
      case (op)
        rau_pkg::OP_ADD: begin
          rn = an * bd + bn * ad;
          rd = ad * bd;
        end
        rau_pkg::OP_SUB: begin
          rn = an * bd - bn * ad;
          rd = ad * bd;
        end
        rau_pkg::OP_MUL: begin
          rn = an * bn;
          rd = ad * bd;
        end
        rau_pkg::OP_DIV: begin
          rn = an * bd;
          rd = ad * bn;
        end
        rau_pkg::OP_CMP: begin
          // literal cross products, so negative denominators flip the sense
          p = an * bd;
          q = bn * ad;
          r.is_equal   = (p == q);
          r.is_less    = (p < q);
          r.is_greater = (q < p);
        end
        default: ;
      endcase
      if (op <= rau_pkg::OP_DIV) begin
        if (rd == 0) begin
          r.status = rau_pkg::STAT_ZERO_RES;
          rn = 0;
        end else begin
          cancel_common(rn, rd);
        end
      end
    end
    r.num = 33'(rn);
    r.den = 32'(rd);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, int an, int ad, int bn, int bd,
                                  bit typed, frac_result_t want);
    stim_row_t row;
    row.op    = op;
    row.an    = 16'(an);
    row.ad    = 16'(ad);
    row.bn    = 16'(bn);
    row.bd    = 16'(bd);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(0, 7))
      0:       return 16'(-32768);
      1:       return 16'(32767);
      2:       return 16'(-32767);
      3:       return 16'(-1);
      4:       return 16'(1);
      5:       return 16'(16384);
      6:       return 16'(-16384);
      default: return 16'(0);
    endcase
  endfunction

  function automatic void pick_fraction(output logic signed [15:0] n,
                                        output logic signed [15:0] d);
    int k, pn, pd;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        n = 16'($urandom);
        d = 16'($urandom);
      end
      4, 5: begin
        // shared factor so the input reduction has real work to do
        k  = $urandom_range(1, 200);
        pn = int'($urandom_range(0, 300)) - 150;
        pd = int'($urandom_range(0, 300)) - 150;
        n  = 16'(k * pn);
        d  = 16'(k * pd);
      end
      6, 7: begin
        n = 16'(int'($urandom_range(0, 60)) - 30);
        d = 16'(int'($urandom_range(0, 60)) - 30);
      end
      8: begin
        n = pick_edge();
        d = pick_edge();
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          n = 16'($urandom);
          d = pick_edge();
        end else begin
          n = pick_edge();
          d = 16'($urandom);
        end
      end
    endcase
    if ($urandom_range(0, 49) == 0)
      d = '0;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic signed [15:0] an,
                           input logic signed [15:0] ad, input logic signed [15:0] bn,
                           input logic signed [15:0] bd, input frac_result_t want);
    in_opcode <= op;
    in_a_num  <= an;
    in_a_den  <= ad;
    in_b_num  <= bn;
    in_b_den  <= bd;
    start     <= 1'b1;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    pending_results.push_back(want);
    words_sent++;
    op_count[op]++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input frac_result_t want,
                               input frac_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"[%0t] %s: want num %0d den %0d st %0d e/l/g %b%b%b,",
                " got num %0d den %0d st %0d e/l/g %b%b%b"},
               $realtime, what, want.num, want.den, want.status, want.is_equal,
               want.is_less, want.is_greater, got.num, got.den, got.status,
               got.is_equal, got.is_less, got.is_greater);
  endtask

  // result monitor: out_valid lasts one cycle and cannot be stalled
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word = '{out_res_num, out_res_den, out_status, out_is_equal,
                   out_is_less, out_is_greater};
      results_seen++;
      if (got_word.status == rau_pkg::STAT_ZERO_IN)
        zero_in_seen++;
      if (got_word.status == rau_pkg::STAT_ZERO_RES)
        zero_res_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", BLANK_WORD, got_word);
      end else begin
        want_word = pending_results.pop_front();
        if (got_word.num !== want_word.num || got_word.den !== want_word.den ||
            got_word.status !== want_word.status ||
            got_word.is_equal !== want_word.is_equal ||
            got_word.is_less !== want_word.is_less ||
            got_word.is_greater !== want_word.is_greater)
          note_mismatch($sformatf("mismatch on result %0d", results_seen),
                        want_word, got_word);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending",
             CYCLE_LIMIT, pending_results.size());
    $display("** rational_arith_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [2:0]         op;
    logic signed [15:0] an, ad, bn, bd;
    int                 burst_left;
    frac_result_t       want;

    foreach (op_count[i])
      op_count[i] = 0;

    add_row(rau_pkg::OP_ADD, 1, 2, 1, 3, 1'b1,
            '{33'sd5, 32'sd6, rau_pkg::STAT_OK, 1'b0, 1'b0, 1'b0});
    add_row(rau_pkg::OP_CMP, 1, 2, 2, 4, 1'b1,
            '{33'sd0, 32'sd0, rau_pkg::STAT_OK, 1'b1, 1'b0, 1'b0});
    add_row(rau_pkg::OP_SUB, 1, 2, 1, 3, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_MUL, 2, 3, 3, 4, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_DIV, 1, 2, 1, 4, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_ADD, 5, 0, 1, 3, 1'b1, ZERO_IN_WORD);
    add_row(rau_pkg::OP_CMP, 5, 7, -32768, 0, 1'b1, ZERO_IN_WORD);
    add_row(OP_SPARE5, 0, 0, 0, 0, 1'b1, ZERO_IN_WORD);
    add_row(rau_pkg::OP_DIV, 3, 4, 0, 5, 1'b1, ZERO_RES_WORD);
    add_row(rau_pkg::OP_DIV, 3, 4, 0, -7, 1'b1, ZERO_RES_WORD);
    add_row(OP_SPARE5, 3, 4, 5, 6, 1'b1, BLANK_WORD);
    add_row(OP_SPARE6, -32768, -1, 32767, 32767, 1'b1, BLANK_WORD);
    add_row(OP_SPARE7, -1, -1, -1, -1, 1'b1, BLANK_WORD);
    // minus one reductions push -32768 up to +32768
    add_row(rau_pkg::OP_MUL, -32768, -1, -32768, -1, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_ADD, -32768, -1, -32768, -1, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_ADD, 32767, -32768, 32767, -32768, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_SUB, -32768, 1, 32767, 1, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_MUL, -32768, 1, -32768, 1, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_DIV, -32768, 1, 1, -32768, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_ADD, 0, 1, 0, -1, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_CMP, -32768, 32767, 32767, -32768, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_ADD, 32767, 32767, -32768, -32768, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_SUB, 1, -2, -1, 2, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_CMP, 1, -2, 1, 2, 1'b0, BLANK_WORD);
    add_row(rau_pkg::OP_DIV, 32767, -32768, -32768, 32767, 1'b0, BLANK_WORD);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want :
             rational_result(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                             directed_rows[i].bn, directed_rows[i].bd);
      send_word(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                directed_rows[i].bn, directed_rows[i].bd, want);
      idle_cycles($urandom_range(0, 2));
    end
    drain_results();

    burst_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i != 0 && i % DRAIN_EVERY == 0) begin
        drain_results();
      end else if (burst_left == 0) begin
        // a quarter of the bursts follow on with no gap at all
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
        burst_left--;
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      pick_fraction(an, ad);
      pick_fraction(bn, bd);
      if (op == rau_pkg::OP_DIV && $urandom_range(0, 19) == 0)
        bn = '0;
      send_word(op, an, ad, bn, bd, rational_result(op, an, ad, bn, bd));
    end

    drain_results();
    repeat (50) @(posedge clk);

    $display("sent %0d words: add %0d sub %0d mul %0d div %0d cmp %0d unused %0d",
             words_sent, op_count[rau_pkg::OP_ADD], op_count[rau_pkg::OP_SUB],
             op_count[rau_pkg::OP_MUL], op_count[rau_pkg::OP_DIV],
             op_count[rau_pkg::OP_CMP],
             op_count[OP_SPARE5] + op_count[OP_SPARE6] + op_count[OP_SPARE7]);
    $display("checked %0d results (%0d zero input den, %0d zero result den), %0d mismatches",
             results_seen, zero_in_seen, zero_res_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** rational_arith_unit: PASSED **");
    else
      $display("** rational_arith_unit: FAILED **");
    $finish;
  end

endmodule

// ===== rational_arith_unit.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_mul.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arith_unit.sv
tb/sv/tb_rational_arith_unit.sv
